### rtl/a2i_pkg.sv
// Shared types and constants for the ASCII-to-integer parser.
`default_nettype none
package a2i_pkg;

    localparam int VALUE_WIDTH_DEF    = 64;
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH        = 2;
    localparam int BASE_WIDTH         = 6;
    localparam int DIGIT_WIDTH        = 6;
    localparam int OFFSET_WIDTH       = 16;
    localparam int OUT_VALUE_WIDTH    = 64;

    localparam logic [BASE_WIDTH-1:0] BASE_RESET   = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_OCTAL   = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DECIMAL = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX     = 6'd16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] UP_LETTER_BIAS  = 8'h37; // 'A' - 10
    localparam logic [7:0] LOW_LETTER_BIAS = 8'h57; // 'a' - 10

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // Classified byte, as it travels from the front end to the back end.
    typedef struct packed {
        logic                   first;
        logic                   is_space;
        logic                   is_minus;
        logic                   is_plus;
        logic                   is_zero;
        logic                   is_x;
        logic                   is_digit;
        logic [DIGIT_WIDTH-1:0] digit;
        logic [BASE_WIDTH-1:0]  base;
    } item_t;

endpackage
`default_nettype wire

### rtl/a2i_front.sv
// Front end: accepts bytes, decodes character classes and digit values.
`default_nettype none
module a2i_front (
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic [a2i_pkg::BASE_WIDTH-1:0]  number_base,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output a2i_pkg::item_t                       q_item
);
    import a2i_pkg::*;

    logic [7:0]             ch;
    logic [DIGIT_WIDTH-1:0] dval;
    logic                   dvalid;

    assign ch = s_tdata;

    always_comb begin
        dvalid = 1'b1;
        if (ch inside {[CH_ZERO:CH_NINE]}) begin
            dval = DIGIT_WIDTH'(ch - CH_ZERO);
        end else if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
            dval = DIGIT_WIDTH'(ch - UP_LETTER_BIAS);
        end else if (ch inside {[CH_LOW_A:CH_LOW_Z]}) begin
            dval = DIGIT_WIDTH'(ch - LOW_LETTER_BIAS);
        end else begin
            dval   = '0;
            dvalid = 1'b0;
        end
    end

    always_comb begin
        q_item.first    = s_tuser;
        q_item.is_space = (ch == CH_SPACE);
        q_item.is_minus = (ch == CH_MINUS);
        q_item.is_plus  = (ch == CH_PLUS);
        q_item.is_zero  = (ch == CH_ZERO);
        q_item.is_x     = (ch == CH_LOW_X) || (ch == CH_UP_X);
        q_item.is_digit = dvalid;
        q_item.digit    = dval;
        // The user, not the block, keeps config static in flight; tag each item.
        q_item.base     = number_base;
    end

    // Reset only gates acceptance; the queue itself is cleared by reset.
    assign s_tready = aresetn && !q_full;
    assign q_push   = s_tvalid && s_tready;

endmodule
`default_nettype wire

### rtl/a2i_queue.sv
// Short queue of classified items between front and back ends.
`default_nettype none
module a2i_queue #(
    parameter int DEPTH = a2i_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire a2i_pkg::item_t  push_item,
    input  wire logic            pop,
    output a2i_pkg::item_t       head_item,
    output logic                 full,
    output logic                 empty
);
    import a2i_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### rtl/a2i_back.sv
// Back end: parse state machine, accumulator and output register.
`default_nettype none
module a2i_back #(
    parameter int VALUE_WIDTH    = a2i_pkg::VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = a2i_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire a2i_pkg::item_t  head_item,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [79:0]          m_tdata,
    output logic [1:0]           m_tuser
);
    import a2i_pkg::*;

    localparam int PROD_W = VALUE_WIDTH + BASE_WIDTH + 1;
    localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    phase_t                    phase_reg, phase_next;
    logic                      neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0]    acc_reg, acc_next;
    logic                      ovf_reg, ovf_next;
    logic                      seen_reg, seen_next;
    logic [BASE_WIDTH-1:0]     abase_reg, abase_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;

    logic                      out_valid_reg, out_valid_next;
    logic [79:0]               out_data_reg, out_data_next;
    logic [1:0]                out_user_reg, out_user_next;

    // Working copies of state as each step of the byte is applied.
    phase_t                    ph;
    logic                      neg;
    logic [VALUE_WIDTH-1:0]    acc;
    logic                      ovf;
    logic                      seen;
    logic [BASE_WIDTH-1:0]     ab;
    logic [POSITION_WIDTH-1:0] here;
    logic                      live;
    logic                      emit;
    logic [BASE_WIDTH-1:0]     eff_base;
    logic [PROD_W-1:0]         sum;
    logic [PROD_W-1:0]         limit;
    logic [VALUE_WIDTH-1:0]    res_value;

    assign q_pop = !q_empty && (!out_valid_reg || m_tready);

    always_comb begin
        ph         = phase_reg;
        neg        = neg_reg;
        acc        = acc_reg;
        ovf        = ovf_reg;
        seen       = seen_reg;
        ab         = abase_reg;
        here       = pos_reg;
        live       = 1'b1;
        emit       = 1'b0;
        eff_base   = BASE_DECIMAL;
        sum        = '0;
        limit      = '0;
        res_value  = '0;

        if (head_item.first) begin
            ph   = PH_LEAD;
            neg  = 1'b0;
            acc  = '0;
            ovf  = 1'b0;
            seen = 1'b0;
            ab   = head_item.base;
            here = '0;
        end else if (phase_reg == PH_IDLE) begin
            live = 1'b0;
        end

        if (live) begin
            if (ph == PH_LEAD) begin
                if (head_item.is_space) begin
                    live = 1'b0;
                end else if (head_item.is_minus) begin
                    neg  = 1'b1;
                    ph   = PH_SIGNED;
                    live = 1'b0;
                end else if (head_item.is_plus) begin
                    ph   = PH_SIGNED;
                    live = 1'b0;
                end else begin
                    ph = PH_SIGNED;
                end
            end
        end

        if (live) begin
            if (ph == PH_SIGNED) begin
                if ((ab == BASE_AUTO || ab == BASE_HEX) && head_item.is_zero) begin
                    ph   = PH_ZERO;
                    live = 1'b0;
                end else begin
                    if (ab == BASE_AUTO) begin
                        ab = BASE_DECIMAL;
                    end
                    ph = PH_DIGITS;
                end
            end else if (ph == PH_ZERO) begin
                if (head_item.is_x) begin
                    ab   = BASE_HEX;
                    ph   = PH_DIGITS;
                    live = 1'b0;
                end else begin
                    if (ab == BASE_AUTO) begin
                        ab = BASE_OCTAL;
                    end
                    seen = 1'b1;
                    ph   = PH_DIGITS;
                end
            end
        end

        if (live) begin
            eff_base = (ab == BASE_AUTO) ? BASE_DECIMAL : ab;
            if (!head_item.is_digit || (head_item.digit >= eff_base)) begin
                emit = 1'b1;
                ph   = PH_IDLE;
            end else begin
                // acc*base + d > limit is the same test as the cutoff compare.
                sum   = PROD_W'(acc) * PROD_W'(eff_base) + PROD_W'(head_item.digit);
                limit = PROD_W'(MAX_POS) + PROD_W'(neg);
                if (ovf || (sum > limit)) begin
                    ovf = 1'b1;
                end else begin
                    acc = sum[VALUE_WIDTH-1:0];
                end
                seen = 1'b1;
            end
        end

        if (ovf) begin
            res_value = neg ? MIN_NEG : MAX_POS;
        end else begin
            res_value = neg ? (~acc + 1'b1) : acc;
        end

        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        seen_next  = seen_reg;
        abase_next = abase_reg;
        pos_next   = pos_reg;
        if (q_pop && (head_item.first || phase_reg != PH_IDLE)) begin
            phase_next = ph;
            neg_next   = neg;
            acc_next   = acc;
            ovf_next   = ovf;
            seen_next  = seen;
            abase_next = ab;
            pos_next   = (here == POS_MAX) ? here : here + 1'b1;
        end

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (q_pop && emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {(seen ? OFFSET_WIDTH'(here) : {OFFSET_WIDTH{1'b0}}),
                              OUT_VALUE_WIDTH'(signed'(res_value))};
            out_user_next  = {seen, ovf};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            abase_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            seen_reg      <= seen_next;
            abase_reg     <= abase_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

### rtl/ascii_to_integer_parser.sv
// ASCII string to signed integer converter, one byte per cycle unless stalled.
//
// Usage:
//   Bytes of a string enter on the s_ channel, s_tdata holding the byte and
//   s_tuser high on the first byte of each string. Leading spaces, a sign and a
//   0x prefix (radix 0 or 16) are taken; digits up to base 36 are accumulated.
//   At the first byte that is not a valid digit one result item leaves on the m_
//   channel: value and end offset in m_tdata, overflow and any-digits flags in
//   m_tuser. Bytes arriving while no string is open are dropped. cfg_we/cfg_wdata
//   set the radix (0 = detect from prefix); it is sampled at each string start.
//   The user writes it only while the block is idle (not enforced by the block).
// Timing:
//   One byte per cycle while the output is not stalled. The byte that ends a
//   string passes through the classify queue, then the accumulate step (one
//   64x6 multiply, add and limit compare) that loads the output register.
//   When m_tready is low the result waits in the output register and the
//   two-entry queue keeps absorbing bytes until it fills, then s_tready drops.
// Reset:
//   aresetn (synchronous, active low) empties the queue, closes any open
//   string, drops a pending result and sets the radix to 10.
`default_nettype none
module ascii_to_integer_parser #(
    parameter int VALUE_WIDTH    = a2i_pkg::VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = a2i_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [a2i_pkg::BASE_WIDTH-1:0] cfg_wdata,   // number_base
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,     // ch
    input  wire logic                           s_tuser,     // first
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [79:0]                         m_tdata,     // value, end_offset
    output logic [1:0]                          m_tuser      // overflow, any_digits
);
    import a2i_pkg::*;

    logic [BASE_WIDTH-1:0] base_reg;
    item_t                 push_item;
    item_t                 head_item;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_we) begin
            base_reg <= cfg_wdata;
        end
    end

    a2i_front u_front (
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .number_base (base_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    a2i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    a2i_back #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the ASCII-to-integer parser, with a behavioral predictor.
`timescale 1ns / 100ps
module tb_top;
    import a2i_pkg::*;

    localparam int          NOT_A_DIGIT    = 255;
    localparam int          SEG_BYTES      = 80;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          LONG_RUN       = 100;
    localparam logic [7:0]  CH_NUL         = 8'h00;
    localparam logic [7:0]  CH_DOT         = 8'h2E;
    localparam logic [63:0] VALUE_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VALUE_MIN      = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0] ch;
        logic       opens;
    } byte_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic        overflow;
        logic        any_digits;
        logic [15:0] end_offset;
    } parse_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [BASE_WIDTH-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // ch
    logic                  s_tuser   = 1'b0; // first
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [79:0]           m_tdata;          // value, end_offset
    logic [1:0]            m_tuser;          // overflow, any_digits

    ascii_to_integer_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    byte_item_t    pending_bytes[$];
    parse_result_t expected_results[$];
    byte_item_t    cur_byte;
    int            send_idle_pct     = 18;
    int            recv_idle_pct     = 52;
    int            bytes_outstanding = 0;
    int unsigned   bytes_queued      = 0;
    int            error_count       = 0;
    int            quiet_cycles      = 0;
    bit            s_taken           = 1'b0;
    bit            mark_first        = 1'b0;
    int            base_plan[18]     = '{0, 16, 2, 36, 1, 63, 8, 37, 10, -1, 0, 16,
                                         -1, 2, 36, 0, -1, 10};

    // Predictor state
    logic [BASE_WIDTH-1:0] cfg_base_shadow = BASE_RESET;
    phase_t                ps_phase        = PH_IDLE;
    bit                    ps_negative     = 1'b0;
    logic [63:0]           ps_acc          = '0;
    bit                    ps_ovf          = 1'b0;
    bit                    ps_seen         = 1'b0;
    logic [BASE_WIDTH-1:0] ps_base         = '0;
    logic [15:0]           ps_pos          = '0;

    function automatic int digit_of(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - UP_LETTER_BIAS);
        if (c >= CH_LOW_A && c <= CH_LOW_Z) return int'(c - LOW_LETTER_BIAS);
        return NOT_A_DIGIT;
    endfunction

    function automatic logic [7:0] digit_char(int unsigned v);
        if (v < 10) return CH_ZERO + 8'(v);
        return (($urandom_range(0, 1) == 1) ? CH_LOW_A : CH_UP_A) + 8'(v - 10);
    endfunction

    // Advance the parse by one accepted byte; push a result when the string ends.
    task automatic parse_byte(input logic [7:0] ch, input logic opens);
        logic [15:0]   here;
        logic [63:0]   radix;
        logic [63:0]   limit;
        logic [63:0]   cutoff;
        logic [63:0]   cutlim;
        int            d;
        parse_result_t r;
        if (opens) begin
            ps_phase    = PH_LEAD;
            ps_negative = 1'b0;
            ps_acc      = '0;
            ps_ovf      = 1'b0;
            ps_seen     = 1'b0;
            ps_base     = cfg_base_shadow;
            ps_pos      = '0;
        end else if (ps_phase == PH_IDLE) begin
            return;
        end
        here = ps_pos;
        if (ps_pos != 16'hFFFF) ps_pos = ps_pos + 16'd1;

        if (ps_phase == PH_LEAD) begin
            if (ch == CH_SPACE) return;
            if (ch == CH_MINUS) begin
                ps_negative = 1'b1;
                ps_phase    = PH_SIGNED;
                return;
            end
            if (ch == CH_PLUS) begin
                ps_phase = PH_SIGNED;
                return;
            end
            ps_phase = PH_SIGNED;
        end
        if (ps_phase == PH_SIGNED) begin
            if ((ps_base == BASE_AUTO || ps_base == BASE_HEX) && ch == CH_ZERO) begin
                ps_phase = PH_ZERO;
                return;
            end
            if (ps_base == BASE_AUTO) ps_base = BASE_DECIMAL;
            ps_phase = PH_DIGITS;
        end else if (ps_phase == PH_ZERO) begin
            if (ch == CH_LOW_X || ch == CH_UP_X) begin
                ps_base  = BASE_HEX;
                ps_phase = PH_DIGITS;
                return;
            end
            // a lone leading zero counts as a digit
            if (ps_base == BASE_AUTO) ps_base = BASE_OCTAL;
            ps_seen  = 1'b1;
            ps_phase = PH_DIGITS;
        end

        radix = (ps_base == BASE_AUTO) ? 64'd10 : 64'(ps_base);
        d = digit_of(ch);
        if (d == NOT_A_DIGIT || 64'(d) >= radix) begin
            if (ps_ovf)
                r.value = ps_negative ? VALUE_MIN : VALUE_MAX;
            else
                r.value = ps_negative ? -ps_acc : ps_acc;
            r.overflow   = ps_ovf;
            r.any_digits = ps_seen;
            r.end_offset = ps_seen ? here : 16'd0;
            expected_results.push_back(r);
            ps_phase = PH_IDLE;
            return;
        end
        limit  = VALUE_MAX + 64'(ps_negative);
        cutoff = limit / radix;
        cutlim = limit % radix;
        // once saturated, keep consuming digits without touching the value
        if (ps_ovf || ps_acc > cutoff || (ps_acc == cutoff && 64'(d) > cutlim))
            ps_ovf = 1'b1;
        else
            ps_acc = ps_acc * radix + 64'(d);
        ps_seen = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic queue_byte(input logic [7:0] ch);
        byte_item_t b;
        b.ch       = ch;
        b.opens    = mark_first;
        mark_first = 1'b0;
        pending_bytes.push_back(b);
        bytes_outstanding++;
        bytes_queued++;
    endtask

    task automatic queue_text(input string txt);
        mark_first = 1'b1;
        for (int i = 0; i < txt.len(); i++) queue_byte(txt[i]);
    endtask

    // Mostly well-formed strings with random content; some noise and cut-short strings.
    task automatic queue_random_string(input logic [BASE_WIDTH-1:0] seg_base);
        int unsigned radix;
        int unsigned ndig;
        logic [63:0] val;
        int unsigned digs[$];
        bit          neg;
        neg = 1'b0;
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 6)) begin
                mark_first = ($urandom_range(0, 2) == 0);
                queue_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        mark_first = 1'b1;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) queue_byte(CH_SPACE);
        case ($urandom_range(0, 2))
            1: begin
                queue_byte(CH_MINUS);
                neg = 1'b1;
            end
            2: queue_byte(CH_PLUS);
            default: ;
        endcase

        if (seg_base == BASE_AUTO) radix = 10;
        else if (seg_base > 36) radix = 36;
        else radix = seg_base;
        if (seg_base == BASE_AUTO || seg_base == BASE_HEX) begin
            case ($urandom_range(0, 3))
                1: begin
                    queue_byte(CH_ZERO);
                    queue_byte(CH_LOW_X);
                    radix = 16;
                end
                2: begin
                    queue_byte(CH_ZERO);
                    queue_byte(CH_UP_X);
                    radix = 16;
                end
                3: begin
                    queue_byte(CH_ZERO);
                    if (seg_base == BASE_AUTO) radix = 8;
                end
                default: ;
            endcase
        end

        if (radix >= 2 && $urandom_range(0, 9) == 0) begin
            // land right at the saturation boundary, one either side or on it
            val = VALUE_MAX + 64'(neg) - 64'd1 + 64'($urandom_range(0, 2));
            while (val != 0) begin
                digs.push_front(int'(val % radix));
                val = val / radix;
            end
        end else begin
            ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 68) : $urandom_range(0, 8);
            repeat (ndig) digs.push_back($urandom_range(0, radix - 1));
        end
        foreach (digs[i]) queue_byte(digit_char(digs[i]));

        case ($urandom_range(0, 9))
            0, 1, 2, 3: queue_byte(CH_NUL);
            4, 5, 6:    queue_byte(8'($urandom_range(0, 255)));
            7:          queue_byte(CH_SPACE);
            8:          ; // leave open; the next start cuts it short
            default:    queue_byte((radix < 36) ? digit_char(radix) : CH_DOT);
        endcase
        if ($urandom_range(0, 7) == 0) queue_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (bytes_outstanding != 0 || expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_base(input logic [BASE_WIDTH-1:0] b);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= b;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Driver: hold an item until taken, otherwise advance or idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!s_tvalid || s_taken) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_byte.ch;
                    s_tuser  <= cur_byte.opens;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
        s_taken = 1'b0;
    end

    // Monitor: predict on accepted bytes, check accepted results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) cfg_base_shadow = cfg_wdata;
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tuser);
                s_taken = 1'b1;
                bytes_outstanding--;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected", m_tdata[63:0], '0);
                end else begin
                    if (m_tdata[63:0] !== expected_results[0].value)
                        report_mismatch("value", m_tdata[63:0], expected_results[0].value);
                    if (m_tuser[0] !== expected_results[0].overflow)
                        report_mismatch("overflow", 64'(m_tuser[0]),
                                        64'(expected_results[0].overflow));
                    if (m_tuser[1] !== expected_results[0].any_digits)
                        report_mismatch("any_digits", 64'(m_tuser[1]),
                                        64'(expected_results[0].any_digits));
                    if (m_tdata[79:64] !== expected_results[0].end_offset)
                        report_mismatch("end_offset", 64'(m_tdata[79:64]),
                                        64'(expected_results[0].end_offset));
                    void'(expected_results.pop_front());
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int                    seg;
        int unsigned           seg_start;
        logic [BASE_WIDTH-1:0] seg_base;
        bit                    held;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: auto radix, sign, bare prefix, lone zero, restart, idle byte
        write_base(BASE_AUTO);
        queue_text(" -42");
        queue_byte(CH_NUL);
        queue_text("+Z");
        mark_first = 1'b0;
        queue_byte(8'hFF);
        queue_text("19");
        queue_text("7.");
        queue_text("0xg");
        queue_text("0");
        queue_byte(CH_NUL);
        queue_text("0XfF");
        queue_byte(CH_NUL);

        for (seg = 0; seg < 18; seg++) begin
            if (seg == 6) begin
                send_idle_pct = 52;
                recv_idle_pct = 18;
            end else if (seg == 12) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            seg_base = (base_plan[seg] < 0) ? BASE_WIDTH'($urandom_range(0, 63))
                                            : BASE_WIDTH'(base_plan[seg]);
            write_base(seg_base);
            seg_start = bytes_queued;
            held      = 1'b0;
            while (bytes_queued - seg_start < SEG_BYTES) begin
                queue_random_string(seg_base);
                // hold the sender once per mode until every result is back
                if (seg % 6 == 2 && !held && bytes_queued - seg_start >= SEG_BYTES / 2) begin
                    wait_drained();
                    held = 1'b1;
                end
            end
        end

        // One long run of zeros ends the stream
        mark_first = 1'b1;
        repeat (LONG_RUN) queue_byte(CH_ZERO);
        queue_byte(CH_DOT);

        wait_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
